// ===== rtl/neumann_series_matrix_inverse_core_macros.svh =====
// assertion macros for the neumann series inverse core
`ifndef NEUMANN_SERIES_MATRIX_INVERSE_CORE_MACROS_SVH
`define NEUMANN_SERIES_MATRIX_INVERSE_CORE_MACROS_SVH

// same-cycle implication
`define NSMI_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("nsmi check failed");

// next-cycle implication
`define NSMI_IMPLIES_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nsmi check failed");

`endif

// ===== rtl/nsmi_pkg.sv =====
// shared types and constants for the neumann series inverse core
package nsmi_pkg;

  localparam int Q_W      = 32;
  localparam int TERM_W   = 7;
  localparam int DVD_W    = 64;
  localparam int DSR_W    = 35;
  localparam logic [TERM_W-1:0] TERM_RST = 7'd10;

  typedef enum logic [2:0] {
    OP_RA,
    OP_RES,
    OP_PR,
    OP_ACC,
    OP_SB
  } op_t;

  typedef struct packed {
    op_t  op;
    logic load_we;
    logic div_start;
    logic div_phase;
    logic sc_we;
    logic mm_vld;
    logic mm_first;
    logic mm_last;
    logic pp_vld;
    logic diag;
    logic out_ld;
    logic out_last;
  } ctl_t;

  typedef struct packed {
    logic zero;
    logic div_done;
  } sts_t;

endpackage

// ===== rtl/nsmi_in_if.sv =====
// input word channel
interface nsmi_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] element_value;
  modport source (output valid, output element_value, input ready);
  modport sink (input valid, input element_value, output ready);
endinterface

// ===== rtl/nsmi_out_if.sv =====
// result word channel
interface nsmi_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] inverse_value;
  logic               last_element;
  logic               zero_norm;
  modport source (output valid, output inverse_value, output last_element,
                  output zero_norm, input ready);
  modport sink (input valid, input inverse_value, input last_element,
                input zero_norm, output ready);
endinterface

// ===== rtl/nsmi_cfg_if.sv =====
// configuration write channel
interface nsmi_cfg_if;
  logic       valid;
  logic       ready;
  logic [6:0] term_count;
  modport source (output valid, output term_count, input ready);
  modport sink (input valid, input term_count, output ready);
endinterface

// ===== rtl/nsmi_div.sv =====
// restoring divider, one quotient bit per cycle
module nsmi_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [nsmi_pkg::DVD_W-1:0] dvd,
  input  logic [nsmi_pkg::DSR_W-1:0] dsr,
  output logic                       done,
  output logic [nsmi_pkg::DVD_W-1:0] quo
);
  import nsmi_pkg::*;

  localparam int CNT_W = $clog2(DVD_W);

  logic [DVD_W-1:0] dvd_r;
  logic [DSR_W-1:0] dsr_r;
  logic [DSR_W-1:0] rem_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DSR_W:0]   trial;
  logic [DSR_W:0]   diff;
  logic             ge;

  assign trial = {rem_r, dvd_r[DVD_W-1]};
  assign ge    = trial >= {1'b0, dsr_r};
  assign diff  = trial - {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        dvd_r  <= dvd;
        dsr_r  <= dsr;
        rem_r  <= '0;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= ge ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
        dvd_r <= {dvd_r[DVD_W-2:0], ge};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == {CNT_W{1'b1}}) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = dvd_r;

endmodule

// ===== rtl/nsmi_dp.sv =====
// datapath: matrix stores, norms, scaling, multiply-accumulate, output word
module nsmi_dp #(
  parameter int DIM = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  nsmi_pkg::ctl_t              ctl,
  input  logic [$clog2(DIM*DIM)-1:0]  addr_a,
  input  logic [$clog2(DIM*DIM)-1:0]  addr_b,
  input  logic [$clog2(DIM*DIM)-1:0]  addr_w,
  input  logic [$clog2(DIM)-1:0]      row,
  input  logic [$clog2(DIM)-1:0]      col,
  input  logic signed [31:0]          in_data,
  output nsmi_pkg::sts_t              sts,
  output logic signed [31:0]          out_value,
  output logic                        out_last,
  output logic                        out_zero
);
  import nsmi_pkg::*;

  localparam int CELLS = DIM * DIM;
  localparam int IW    = $clog2(DIM);
  localparam int AW    = $clog2(CELLS);
  localparam logic [IW-1:0] IMAX = IW'(DIM - 1);
  localparam logic signed [31:0] ONE_Q = 32'sh0100_0000;

  function automatic logic signed [31:0] sat32(input logic signed [44:0] v);
    logic signed [31:0] r;
    if (v > 45'sh0_7FFF_FFFF) r = 32'sh7FFF_FFFF;
    else if (v < -45'sh0_8000_0000) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  logic signed [31:0] src_m [CELLS];
  logic signed [31:0] scl_m [CELLS];
  logic signed [31:0] res_m [CELLS];
  logic signed [31:0] pow_m [CELLS];
  logic signed [31:0] sum_m [CELLS];
  logic signed [31:0] prd_m [CELLS];

  logic signed [31:0] src_rd_r, scl_rd_r, res_rd_r, pow_rd_r, sum_rd_r, prd_rd_r;
  logic [AW-1:0]      scl_ra;

  // norms
  logic [DSR_W-1:0] col_acc_r [DIM];
  logic [DSR_W-1:0] row_acc_r, cmax_r, rmax_r;
  logic [31:0]      in_mag;
  logic [DSR_W-1:0] col_sum, row_sum, cmax_base, rmax_base;
  logic             first_w;

  // scaling
  logic [DVD_W-1:0]   div_dvd, div_quo;
  logic [DSR_W-1:0]   div_dsr;
  logic               div_done;
  logic [31:0]        src_mag;
  logic               sgn_r;
  logic               big;
  logic signed [31:0] scl_val;

  // multiply-accumulate pipeline
  logic signed [31:0] x_d, y_d;
  logic               s1_vld_r, s2_vld_r, s3_vld_r;
  logic               s1_first_r, s2_first_r, s3_first_r;
  logic               s1_last_r, s2_last_r, s3_last_r;
  logic [AW-1:0]      s1_addr_r, s2_addr_r, s3_addr_r;
  logic signed [63:0] prod_r;
  logic signed [63:0] prod_rnd;
  logic signed [39:0] rnd_r;
  logic signed [43:0] acc_r, acc_nxt;

  // elementwise pass
  logic               p1_vld_r, p1_diag_r;
  logic [AW-1:0]      p1_addr_r;
  logic signed [31:0] id_val;

  assign scl_ra = (ctl.op == OP_SB) ? addr_b : addr_a;

  always_ff @(posedge clk) begin
    src_rd_r <= src_m[addr_b];
    scl_rd_r <= scl_m[scl_ra];
    res_rd_r <= res_m[addr_b];
    pow_rd_r <= pow_m[addr_a];
    sum_rd_r <= sum_m[addr_a];
    prd_rd_r <= prd_m[addr_a];
  end

  // load and norm tracking
  assign in_mag    = in_data[31] ? 32'(-in_data) : 32'(in_data);
  assign first_w   = (row == '0) && (col == '0);
  assign col_sum   = ((row == '0) ? '0 : col_acc_r[col]) + DSR_W'(in_mag);
  assign row_sum   = ((col == '0) ? '0 : row_acc_r) + DSR_W'(in_mag);
  assign cmax_base = first_w ? '0 : cmax_r;
  assign rmax_base = first_w ? '0 : rmax_r;

  always_ff @(posedge clk) begin
    if (ctl.load_we) begin
      src_m[addr_w]  <= in_data;
      col_acc_r[col] <= col_sum;
      row_acc_r      <= row_sum;
      cmax_r <= (row == IMAX && col_sum > cmax_base) ? col_sum : cmax_base;
      rmax_r <= (col == IMAX && row_sum > rmax_base) ? row_sum : rmax_base;
    end
  end

  assign sts.zero     = (cmax_r == '0) || (rmax_r == '0);
  assign sts.div_done = div_done;

  // scaling by the two norms
  assign src_mag = src_rd_r[31] ? 32'(-src_rd_r) : 32'(src_rd_r);
  assign div_dvd = ctl.div_phase ? {div_quo[39:0], 24'd0} : {8'd0, src_mag, 24'd0};
  assign div_dsr = ctl.div_phase ? rmax_r : cmax_r;

  nsmi_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (ctl.div_start),
    .dvd   (div_dvd),
    .dsr   (div_dsr),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign big = |div_quo[DVD_W-1:31];
  always_comb begin
    if (sgn_r) scl_val = big ? 32'sh8000_0000 : -$signed(div_quo[31:0]);
    else       scl_val = big ? 32'sh7FFF_FFFF : $signed(div_quo[31:0]);
  end

  always_ff @(posedge clk) begin
    if (ctl.div_start && !ctl.div_phase) sgn_r <= src_rd_r[31];
    if (ctl.sc_we) scl_m[addr_w] <= scl_val;
  end

  // operand selection
  always_comb begin
    case (ctl.op)
      OP_RA:   begin x_d = scl_rd_r; y_d = src_rd_r; end
      OP_PR:   begin x_d = pow_rd_r; y_d = res_rd_r; end
      OP_SB:   begin x_d = sum_rd_r; y_d = scl_rd_r; end
      default: begin x_d = scl_rd_r; y_d = src_rd_r; end
    endcase
  end

  assign prod_rnd = (prod_r + 64'sd8388608) >>> 24;
  assign acc_nxt  = (s3_first_r ? 44'sd0 : acc_r) + 44'(rnd_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      p1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= ctl.mm_vld;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      p1_vld_r <= ctl.pp_vld;
    end
  end

  always_ff @(posedge clk) begin
    s1_first_r <= ctl.mm_first;
    s1_last_r  <= ctl.mm_last;
    s1_addr_r  <= addr_w;
    s2_first_r <= s1_first_r;
    s2_last_r  <= s1_last_r;
    s2_addr_r  <= s1_addr_r;
    s3_first_r <= s2_first_r;
    s3_last_r  <= s2_last_r;
    s3_addr_r  <= s2_addr_r;
    prod_r     <= x_d * y_d;
    rnd_r      <= prod_rnd[39:0];
    if (s3_vld_r) begin
      acc_r <= acc_nxt;
      if (s3_last_r) prd_m[s3_addr_r] <= sat32(45'(acc_nxt));
    end
  end

  // elementwise pass over the product
  assign id_val = p1_diag_r ? ONE_Q : 32'sd0;

  always_ff @(posedge clk) begin
    p1_addr_r <= addr_w;
    p1_diag_r <= ctl.diag;
    if (p1_vld_r) begin
      if (ctl.op == OP_RES) begin
        res_m[p1_addr_r] <= sat32(45'(id_val) - 45'(prd_rd_r));
        pow_m[p1_addr_r] <= id_val;
        sum_m[p1_addr_r] <= id_val;
      end else begin
        pow_m[p1_addr_r] <= prd_rd_r;
        sum_m[p1_addr_r] <= sat32(45'(sum_rd_r) + 45'(prd_rd_r));
      end
    end
  end

  // output word
  always_ff @(posedge clk) begin
    if (ctl.out_ld) begin
      out_value <= sts.zero ? 32'sd0 : prd_rd_r;
      out_last  <= ctl.out_last;
      out_zero  <= sts.zero;
    end
  end

endmodule

// ===== rtl/nsmi_ctrl.sv =====
// controller: load, scale, product and series sequencing, result handshake
module nsmi_ctrl #(
  parameter int DIM = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  output logic                         out_valid,
  input  logic                         out_ready,
  input  logic                         cfg_we,
  input  logic [nsmi_pkg::TERM_W-1:0]  cfg_data,
  input  nsmi_pkg::sts_t               sts,
  output nsmi_pkg::ctl_t               ctl,
  output logic [$clog2(DIM*DIM)-1:0]   addr_a,
  output logic [$clog2(DIM*DIM)-1:0]   addr_b,
  output logic [$clog2(DIM*DIM)-1:0]   addr_w,
  output logic [$clog2(DIM)-1:0]       row,
  output logic [$clog2(DIM)-1:0]       col
);
  import nsmi_pkg::*;

  localparam int IW = $clog2(DIM);
  localparam int AW = $clog2(DIM * DIM);
  localparam logic [IW-1:0] IMAX = IW'(DIM - 1);

  typedef enum logic [3:0] {
    S_LOAD,
    S_CHK,
    S_SC_RD,
    S_SC_D1,
    S_SC_W1,
    S_SC_D2,
    S_SC_W2,
    S_MM,
    S_MM_DR,
    S_PP,
    S_PP_DR,
    S_OUT_RD,
    S_OUT_LD,
    S_OUT_WT
  } state_t;

  state_t            state_r;
  logic [IW-1:0]     i_r, j_r, k_r;
  logic [1:0]        drn_r;
  logic [TERM_W-1:0] iter_r, term_r, done_cnt;
  op_t               op_r;
  logic              out_valid_r;
  logic              last_ij;
  logic [AW-1:0]     addr_ij, addr_ji, addr_ik, addr_kj;

  assign last_ij = (i_r == IMAX) && (j_r == IMAX);
  assign addr_ij = AW'(i_r * DIM + j_r);
  assign addr_ji = AW'(j_r * DIM + i_r);
  assign addr_ik = AW'(i_r * DIM + k_r);
  assign addr_kj = AW'(k_r * DIM + j_r);
  assign done_cnt = (op_r == OP_RES) ? '0 : iter_r + 1'b1;

  assign row       = i_r;
  assign col       = j_r;
  assign out_valid = out_valid_r;
  assign in_ready  = (state_r == S_LOAD);

  always_comb begin
    ctl    = '0;
    ctl.op = op_r;
    addr_a = addr_ij;
    addr_b = addr_kj;
    addr_w = addr_ij;
    case (state_r)
      S_LOAD:  ctl.load_we = in_valid;
      S_SC_RD: addr_b = addr_ji;
      S_SC_D1: ctl.div_start = 1'b1;
      S_SC_D2: begin
        ctl.div_start = 1'b1;
        ctl.div_phase = 1'b1;
      end
      S_SC_W2: begin
        ctl.div_phase = 1'b1;
        ctl.sc_we     = sts.div_done;
      end
      S_MM: begin
        ctl.mm_vld   = 1'b1;
        ctl.mm_first = (k_r == '0);
        ctl.mm_last  = (k_r == IMAX);
        addr_a       = addr_ik;
      end
      S_PP: begin
        ctl.pp_vld = 1'b1;
        ctl.diag   = (i_r == j_r);
      end
      S_OUT_LD: begin
        ctl.out_ld   = 1'b1;
        ctl.out_last = last_ij;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      i_r         <= '0;
      j_r         <= '0;
      k_r         <= '0;
      drn_r       <= '0;
      iter_r      <= '0;
      term_r      <= TERM_RST;
      op_r        <= OP_RA;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) term_r <= cfg_data;
      case (state_r)
        S_LOAD: begin
          if (in_valid) begin
            if (j_r == IMAX) begin
              j_r <= '0;
              i_r <= last_ij ? '0 : i_r + 1'b1;
            end else begin
              j_r <= j_r + 1'b1;
            end
            if (last_ij) state_r <= S_CHK;
          end
        end
        S_CHK:   state_r <= sts.zero ? S_OUT_RD : S_SC_RD;
        S_SC_RD: state_r <= S_SC_D1;
        S_SC_D1: state_r <= S_SC_W1;
        S_SC_W1: if (sts.div_done) state_r <= S_SC_D2;
        S_SC_D2: state_r <= S_SC_W2;
        S_SC_W2: begin
          if (sts.div_done) begin
            if (j_r == IMAX) begin
              j_r <= '0;
              i_r <= last_ij ? '0 : i_r + 1'b1;
            end else begin
              j_r <= j_r + 1'b1;
            end
            if (last_ij) begin
              op_r    <= OP_RA;
              k_r     <= '0;
              state_r <= S_MM;
            end else begin
              state_r <= S_SC_RD;
            end
          end
        end
        S_MM: begin
          if (k_r == IMAX) begin
            k_r <= '0;
            if (j_r == IMAX) begin
              j_r <= '0;
              i_r <= last_ij ? '0 : i_r + 1'b1;
            end else begin
              j_r <= j_r + 1'b1;
            end
            if (last_ij) begin
              drn_r   <= '0;
              state_r <= S_MM_DR;
            end
          end else begin
            k_r <= k_r + 1'b1;
          end
        end
        S_MM_DR: begin
          drn_r <= drn_r + 1'b1;
          if (drn_r == 2'd2) begin
            case (op_r)
              OP_RA: begin
                op_r    <= OP_RES;
                state_r <= S_PP;
              end
              OP_PR: begin
                op_r    <= OP_ACC;
                state_r <= S_PP;
              end
              default: state_r <= S_OUT_RD;
            endcase
          end
        end
        S_PP: begin
          if (j_r == IMAX) begin
            j_r <= '0;
            i_r <= last_ij ? '0 : i_r + 1'b1;
          end else begin
            j_r <= j_r + 1'b1;
          end
          if (last_ij) state_r <= S_PP_DR;
        end
        S_PP_DR: begin
          iter_r  <= done_cnt;
          op_r    <= ({1'b0, done_cnt} + 1'b1 < {1'b0, term_r}) ? OP_PR : OP_SB;
          k_r     <= '0;
          state_r <= S_MM;
        end
        S_OUT_RD: state_r <= S_OUT_LD;
        S_OUT_LD: begin
          out_valid_r <= 1'b1;
          state_r     <= S_OUT_WT;
        end
        S_OUT_WT: begin
          if (out_ready) begin
            out_valid_r <= 1'b0;
            if (j_r == IMAX) begin
              j_r <= '0;
              i_r <= last_ij ? '0 : i_r + 1'b1;
            end else begin
              j_r <= j_r + 1'b1;
            end
            state_r <= last_ij ? S_LOAD : S_OUT_RD;
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

endmodule

// ===== rtl/neumann_series_matrix_inverse_core.sv =====
// DIM*DIM load words at one per cycle while in_valid is high, then the scaling of each element
// (two 64-step serial divisions per element), then the matrix products
// on the single multiply-accumulate pipeline (a term_count of zero counts as one),
// then the result words, each held until out_ready takes it
// one matrix at a time: no input word is taken from the last load word until the last result
// synchronous active-low reset clears control state and sets term_count to 10; stores are not cleared
module neumann_series_matrix_inverse_core #(
  parameter int DIM = 8
) (
  input logic      clk,
  input logic      rst_n,
  nsmi_in_if.sink  in_ch,
  nsmi_out_if.source out_ch,
  nsmi_cfg_if.sink cfg_ch
);
  import nsmi_pkg::*;

  ctl_t                      ctl;
  sts_t                      sts;
  logic [$clog2(DIM*DIM)-1:0] addr_a, addr_b, addr_w;
  logic [$clog2(DIM)-1:0]     row, col;

  assign cfg_ch.ready = 1'b1;

  nsmi_ctrl #(.DIM(DIM)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cfg_we    (cfg_ch.valid),
    .cfg_data  (cfg_ch.term_count),
    .sts       (sts),
    .ctl       (ctl),
    .addr_a    (addr_a),
    .addr_b    (addr_b),
    .addr_w    (addr_w),
    .row       (row),
    .col       (col)
  );

  nsmi_dp #(.DIM(DIM)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .addr_a    (addr_a),
    .addr_b    (addr_b),
    .addr_w    (addr_w),
    .row       (row),
    .col       (col),
    .in_data   (in_ch.element_value),
    .sts       (sts),
    .out_value (out_ch.inverse_value),
    .out_last  (out_ch.last_element),
    .out_zero  (out_ch.zero_norm)
  );

endmodule

// ===== rtl/nsmi_chk.sv =====
// port-level checks for the neumann series inverse core
`include "neumann_series_matrix_inverse_core_macros.svh"

module nsmi_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_inverse_value,
  input logic        out_last_element,
  input logic        out_zero_norm
);

  `NSMI_IMPLIES(a_no_load_while_out, in_valid && in_ready, !out_valid)
  `NSMI_IMPLIES(a_zero_gives_zero, out_valid && out_zero_norm, out_inverse_value == 32'd0)
  `NSMI_IMPLIES_NEXT(a_out_holds, out_valid && !out_ready, out_valid && $stable(out_inverse_value))
  `NSMI_IMPLIES_NEXT(a_last_ends, out_valid && out_ready && out_last_element, !out_valid && in_ready)

endmodule

bind neumann_series_matrix_inverse_core nsmi_chk u_nsmi_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_inverse_value (out_ch.inverse_value),
  .out_last_element  (out_ch.last_element),
  .out_zero_norm     (out_ch.zero_norm)
);
